/* src/ens_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ens_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int CFG_W_W  = 12;
    localparam int CFG_H_W  = 13;
    localparam int MAG_W    = 8;
    localparam int DIR_W    = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Register indexes on the APB port (byte address is 4 * index)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [DIR_W-1:0] {
        DIR_HORZ = 2'd0,
        DIR_DIAG = 2'd1,
        DIR_VERT = 2'd2,
        DIR_ANTI = 2'd3
    } dir_t;

    // One line-store entry: direction of row-1, magnitude of row-1, magnitude of row-2
    typedef struct packed {
        logic [DIR_W-1:0] dir_up;
        logic [MAG_W-1:0] mag_up;
        logic [MAG_W-1:0] mag_up2;
    } ls_word_t;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        ls_word_t         word;
    } ls_wr_t;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
    } ls_rd_t;

    // New right-hand window column plus the direction of the next centre
    typedef struct packed {
        logic             adv;
        logic [MAG_W-1:0] top;
        logic [MAG_W-1:0] mid;
        logic [MAG_W-1:0] bot;
        logic [DIR_W-1:0] next_dir;
    } win_col_t;

endpackage

`default_nettype wire

/* src/ens_line_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module ens_line_store (
    input  wire logic             clk,
    input  wire ens_pkg::ls_rd_t  rd,
    input  wire ens_pkg::ls_wr_t  wr,
    output ens_pkg::ls_word_t     rd_word
);

    ens_pkg::ls_word_t mem [ens_pkg::MAX_WIDTH];
    ens_pkg::ls_word_t rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.word;
        end
    end

    // Read data is held until the next read
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_word_reg <= mem[rd.addr];
        end
    end

    assign rd_word = rd_word_reg;

endmodule

`default_nettype wire

/* src/ens_window.sv */
`timescale 1ns / 1ps
`default_nettype none

module ens_window (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ens_pkg::win_col_t          col,
    output logic [ens_pkg::MAG_W-1:0]       kept
);

    // cells 0..2: left column, 3..5: middle column, top to bottom
    logic [ens_pkg::MAG_W-1:0] win_reg [6];
    ens_pkg::dir_t             cdir_reg;
    logic [ens_pkg::MAG_W-1:0] n1;
    logic [ens_pkg::MAG_W-1:0] n2;
    logic [ens_pkg::MAG_W-1:0] centre;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
            cdir_reg <= ens_pkg::DIR_HORZ;
        end
        else if (col.adv)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= col.top;
            win_reg[4] <= col.mid;
            win_reg[5] <= col.bot;
            cdir_reg   <= ens_pkg::dir_t'(col.next_dir);
        end
    end

    always_comb
    begin
        centre = win_reg[4];
        case (cdir_reg)
            ens_pkg::DIR_HORZ:
            begin
                n1 = win_reg[1];
                n2 = col.mid;
            end
            ens_pkg::DIR_DIAG:
            begin
                n1 = win_reg[0];
                n2 = col.bot;
            end
            ens_pkg::DIR_VERT:
            begin
                n1 = win_reg[3];
                n2 = win_reg[5];
            end
            default:
            begin
                n1 = col.top;
                n2 = win_reg[2];
            end
        endcase
        kept = (centre >= n1 && centre >= n2) ? centre : '0;
    end

endmodule

`default_nettype wire

/* src/edge_non_max_suppression.sv */
// Canny non-maximum suppression over a 3x3 neighbourhood, streaming.
// Input channel: one item per pixel in raster order (magnitude, direction),
// handshake in_valid / in_stall. Output channel: one item per interior pixel
// (kept_value, pixel_column, pixel_row, frame_last), handshake out_valid /
// out_stall. Border pixels produce no item; the consumer fills them with zero.
// An item for the interior pixel (r,c) comes from the input pixel (r+1,c+1),
// which passes the line-store read, then the output register. Throughput: one
// pixel per clock while the output is not held; the single-port-read line-store
// RAM plus one pipeline stage sets that figure. A held output still lets pixels
// that give no result (first two rows/columns) pass, and a pixel is accepted
// while the output register waits as long as the processing stage is free.
// Configuration: image_width at 0x0, image_height at 0x4 over APB; values are
// clamped to 3..2048 and 3..4096. Write only while the stream is idle.
// Reset (rst_n, async low) clears counters, window and handshake state; the
// line store is not cleared and needs no clearing pass: each entry is written in
// row 0 before its data reach a result. Stalling the output holds the result.
`timescale 1ns / 1ps
`default_nettype none

module edge_non_max_suppression (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // APB configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ens_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ens_pkg::PDATA_W-1:0]   pwdata,
    output logic [ens_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    // pixel input
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ens_pkg::MAG_W-1:0]     magnitude,
    input  wire logic [ens_pkg::DIR_W-1:0]     direction,
    // result output
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ens_pkg::MAG_W-1:0]          kept_value,
    output logic [ens_pkg::COL_W-1:0]          pixel_column,
    output logic [ens_pkg::ROW_W-1:0]          pixel_row,
    output logic                               frame_last
);

    // ---------------- configuration registers ----------------
    logic [ens_pkg::CFG_W_W-1:0] image_width_reg;
    logic [ens_pkg::CFG_H_W-1:0] image_height_reg;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= ens_pkg::CFG_W_W'(640);
            image_height_reg <= ens_pkg::CFG_H_W'(480);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                ens_pkg::REG_WIDTH:  image_width_reg  <= pwdata[ens_pkg::CFG_W_W-1:0];
                ens_pkg::REG_HEIGHT: image_height_reg <= pwdata[ens_pkg::CFG_H_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ens_pkg::REG_WIDTH:
                prdata = {{(ens_pkg::PDATA_W-ens_pkg::CFG_W_W){1'b0}}, image_width_reg};
            ens_pkg::REG_HEIGHT:
                prdata = {{(ens_pkg::PDATA_W-ens_pkg::CFG_H_W){1'b0}}, image_height_reg};
            default:
                prdata = '0;
        endcase
    end

    // Effective frame size, clamped to the supported range
    logic [ens_pkg::CFG_W_W-1:0] width_eff;
    logic [ens_pkg::CFG_H_W-1:0] height_eff;

    always_comb
    begin
        if (image_width_reg < ens_pkg::CFG_W_W'(3))
            width_eff = ens_pkg::CFG_W_W'(3);
        else if (image_width_reg > ens_pkg::CFG_W_W'(ens_pkg::MAX_WIDTH))
            width_eff = ens_pkg::CFG_W_W'(ens_pkg::MAX_WIDTH);
        else
            width_eff = image_width_reg;

        if (image_height_reg < ens_pkg::CFG_H_W'(3))
            height_eff = ens_pkg::CFG_H_W'(3);
        else if (image_height_reg > ens_pkg::CFG_H_W'(ens_pkg::MAX_HEIGHT))
            height_eff = ens_pkg::CFG_H_W'(ens_pkg::MAX_HEIGHT);
        else
            height_eff = image_height_reg;
    end

    // ---------------- handshake ----------------
    logic s1_valid_reg;
    logic s1_emit_reg;
    logic s1_last_reg;
    logic [ens_pkg::MAG_W-1:0] s1_mag_reg;
    logic [ens_pkg::DIR_W-1:0] s1_dir_reg;
    logic [ens_pkg::COL_W-1:0] s1_col_reg;
    logic [ens_pkg::ROW_W-1:0] s1_row_reg;

    logic out_valid_reg;
    logic out_free;
    logic s1_fire;
    logic accept;

    // Output slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    // Stage 1 moves on unless it has a result and the output slot is busy
    assign s1_fire  = s1_valid_reg && (!s1_emit_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign accept   = in_valid && !in_stall;

    // ---------------- position counters (stage 0) ----------------
    logic [ens_pkg::COL_W-1:0] col_count_reg, col_count_next;
    logic [ens_pkg::ROW_W-1:0] row_count_reg, row_count_next;
    logic                      col_wrap;
    logic                      row_wrap;

    assign col_wrap = ({1'b0, col_count_reg} + ens_pkg::CFG_W_W'(1)) >= width_eff;
    assign row_wrap = ({1'b0, row_count_reg} + ens_pkg::CFG_H_W'(1)) >= height_eff;

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_count_next = '0;
                row_count_next = row_wrap ? '0 : row_count_reg + ens_pkg::ROW_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + ens_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ---------------- stage 1: pixel waiting on its line-store read ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mag_reg  <= magnitude;
            s1_dir_reg  <= direction;
            s1_col_reg  <= col_count_reg;
            s1_row_reg  <= row_count_reg;
            s1_emit_reg <= (col_count_reg >= ens_pkg::COL_W'(2))
                           && (row_count_reg >= ens_pkg::ROW_W'(2));
            s1_last_reg <= col_wrap && row_wrap;
        end
    end

    // ---------------- line store ----------------
    // Read issued as the pixel is accepted; write-back when it leaves stage 1.
    // Consecutive pixels never share a column, so read and write never collide.
    ens_pkg::ls_rd_t   ls_rd;
    ens_pkg::ls_wr_t   ls_wr;
    ens_pkg::ls_word_t ls_word;

    assign ls_rd.en   = accept;
    assign ls_rd.addr = col_count_reg;

    assign ls_wr.en           = s1_fire;
    assign ls_wr.addr         = s1_col_reg;
    assign ls_wr.word.dir_up  = s1_dir_reg;
    assign ls_wr.word.mag_up  = s1_mag_reg;
    assign ls_wr.word.mag_up2 = ls_word.mag_up;

    ens_line_store u_line_store (
        .clk     (clk),
        .rd      (ls_rd),
        .wr      (ls_wr),
        .rd_word (ls_word)
    );

    // ---------------- 3x3 window and suppression test ----------------
    ens_pkg::win_col_t          win_col;
    logic [ens_pkg::MAG_W-1:0]  win_kept;

    assign win_col.adv      = s1_fire;
    assign win_col.top      = ls_word.mag_up2;
    assign win_col.mid      = ls_word.mag_up;
    assign win_col.bot      = s1_mag_reg;
    assign win_col.next_dir = ls_word.dir_up;

    ens_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .col   (win_col),
        .kept  (win_kept)
    );

    // ---------------- output register ----------------
    logic [ens_pkg::MAG_W-1:0] kept_value_reg;
    logic [ens_pkg::COL_W-1:0] pixel_column_reg;
    logic [ens_pkg::ROW_W-1:0] pixel_row_reg;
    logic                      frame_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_emit_reg)
        begin
            kept_value_reg   <= win_kept;
            pixel_column_reg <= s1_col_reg - ens_pkg::COL_W'(1);
            pixel_row_reg    <= s1_row_reg - ens_pkg::ROW_W'(1);
            frame_last_reg   <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kept_value   = kept_value_reg;
    assign pixel_column = pixel_column_reg;
    assign pixel_row    = pixel_row_reg;
    assign frame_last   = frame_last_reg;

    // ---------------- assertions ----------------
    // An accepted pixel always occupies stage 1 next cycle
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel missing from stage 1");

    // Input is only held back by a stage-1 pixel with a result and a busy output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_emit_reg && out_valid_reg && out_stall))
        else $error("input stalled without cause");

    // A stalled result is kept for the next cycle
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(pixel_column_reg)
                                          && $stable(pixel_row_reg)))
        else $error("stalled result lost");

    // Results only describe interior pixels
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (pixel_column_reg != '0 && pixel_row_reg != '0))
        else $error("border pixel emitted");

endmodule

`default_nettype wire
